[sv/mbas_pkg.sv]
// shared types, constants, rule table and control store of the block automaton step core
`default_nettype none
package mbas_pkg;

   // grid geometry
   localparam int unsigned MAX_COLUMNS = 64;
   localparam int unsigned MAX_ROWS    = 64;
   localparam int unsigned COL_W       = $clog2(MAX_COLUMNS);
   localparam int unsigned ROW_W       = $clog2(MAX_ROWS);
   localparam int unsigned ADDR_W      = ROW_W + COL_W;
   localparam int unsigned GRID_DEPTH  = 2 ** ADDR_W;

   // field widths
   localparam int unsigned CELL_W     = 2;
   localparam int unsigned OP_W       = 2;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned DIM_W      = 7;
   localparam int unsigned SUM_W      = DIM_W + 1;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned STEP_W     = 4;

   // configuration register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLUMNS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS    = 1'd1;
   localparam logic [DIM_W-1:0]     GRID_COLUMNS_RST = 7'd64;
   localparam logic [DIM_W-1:0]     GRID_ROWS_RST    = 7'd64;

   // operation codes
   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_GEN   = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ODD   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   // cell codes
   localparam logic [CELL_W-1:0] CELL_E    = 2'd0;
   localparam logic [CELL_W-1:0] CELL_P    = 2'd1;
   localparam logic [CELL_W-1:0] CELL_WALL = 2'd2;

   // 2x2 block: element 0 top-left, 1 top-right, 2 bottom-left, 3 bottom-right
   typedef logic [0:3][CELL_W-1:0] blk_type;

   typedef logic [STEP_W-1:0] step_type;

   // control store addresses
   localparam step_type STEP_CLEAR    = 4'd0;
   localparam step_type STEP_IDLE     = 4'd1;
   localparam step_type STEP_WRITE    = 4'd2;
   localparam step_type STEP_READ     = 4'd3;
   localparam step_type STEP_READ_OUT = 4'd4;
   localparam step_type STEP_RD0      = 4'd5;
   localparam step_type STEP_RD1      = 4'd6;
   localparam step_type STEP_RD2      = 4'd7;
   localparam step_type STEP_RD3      = 4'd8;
   localparam step_type STEP_MATCH    = 4'd9;
   localparam step_type STEP_WR0      = 4'd10;
   localparam step_type STEP_WR1      = 4'd11;
   localparam step_type STEP_WR2      = 4'd12;
   localparam step_type STEP_WR3      = 4'd13;
   localparam step_type STEP_RESP     = 4'd14;

   typedef enum logic [1:0] {
      MEM_NONE,
      MEM_READ,
      MEM_WRITE
   } mem_op_type;

   typedef enum logic [1:0] {
      ADDR_CLEAR,
      ADDR_REQ,
      ADDR_BLK
   } addr_sel_type;

   typedef enum logic [1:0] {
      WD_ZERO,
      WD_REQ,
      WD_REPL
   } wdata_sel_type;

   typedef enum logic [1:0] {
      OUT_NONE,
      OUT_READ,
      OUT_STATUS
   } out_sel_type;

   typedef enum logic [2:0] {
      BR_NEXT,
      BR_ALWAYS,
      BR_DISPATCH,
      BR_CLR_MORE,
      BR_BLK_MORE
   } branch_type;

   typedef struct packed {
      logic          take_req;
      mem_op_type    mem_op;
      addr_sel_type  addr_sel;
      logic [1:0]    cell_sel;
      wdata_sel_type wdata_sel;
      logic          latch_en;
      logic [1:0]    latch_idx;
      logic          latch_repl;
      logic          clr_inc;
      logic          blk_adv;
      out_sel_type   out_sel;
      branch_type    br_cond;
      step_type      br_target;
   } ucode_type;

   // control store
   function automatic ucode_type ucode_word(input step_type step);
      ucode_type w;
      w = '0;
      case (step)
         STEP_CLEAR: begin
            w.mem_op    = MEM_WRITE;
            w.addr_sel  = ADDR_CLEAR;
            w.wdata_sel = WD_ZERO;
            w.clr_inc   = 1'b1;
            w.br_cond   = BR_CLR_MORE;
            w.br_target = STEP_CLEAR;
         end
         STEP_IDLE: begin
            w.take_req  = 1'b1;
            w.br_cond   = BR_DISPATCH;
            w.br_target = STEP_IDLE;
         end
         STEP_WRITE: begin
            w.mem_op    = MEM_WRITE;
            w.addr_sel  = ADDR_REQ;
            w.wdata_sel = WD_REQ;
            w.br_cond   = BR_ALWAYS;
            w.br_target = STEP_RESP;
         end
         STEP_READ: begin
            w.mem_op   = MEM_READ;
            w.addr_sel = ADDR_REQ;
            w.br_cond  = BR_NEXT;
         end
         STEP_READ_OUT: begin
            w.out_sel   = OUT_READ;
            w.br_cond   = BR_ALWAYS;
            w.br_target = STEP_IDLE;
         end
         STEP_RD0: begin
            w.mem_op   = MEM_READ;
            w.addr_sel = ADDR_BLK;
            w.cell_sel = 2'd0;
            w.br_cond  = BR_NEXT;
         end
         STEP_RD1: begin
            w.mem_op    = MEM_READ;
            w.addr_sel  = ADDR_BLK;
            w.cell_sel  = 2'd1;
            w.latch_en  = 1'b1;
            w.latch_idx = 2'd0;
            w.br_cond   = BR_NEXT;
         end
         STEP_RD2: begin
            w.mem_op    = MEM_READ;
            w.addr_sel  = ADDR_BLK;
            w.cell_sel  = 2'd2;
            w.latch_en  = 1'b1;
            w.latch_idx = 2'd1;
            w.br_cond   = BR_NEXT;
         end
         STEP_RD3: begin
            w.mem_op    = MEM_READ;
            w.addr_sel  = ADDR_BLK;
            w.cell_sel  = 2'd3;
            w.latch_en  = 1'b1;
            w.latch_idx = 2'd2;
            w.br_cond   = BR_NEXT;
         end
         STEP_MATCH: begin
            w.latch_repl = 1'b1;
            w.br_cond    = BR_NEXT;
         end
         STEP_WR0, STEP_WR1, STEP_WR2: begin
            w.mem_op    = MEM_WRITE;
            w.addr_sel  = ADDR_BLK;
            w.cell_sel  = 2'(step - STEP_WR0);
            w.wdata_sel = WD_REPL;
            w.br_cond   = BR_NEXT;
         end
         STEP_WR3: begin
            w.mem_op    = MEM_WRITE;
            w.addr_sel  = ADDR_BLK;
            w.cell_sel  = 2'd3;
            w.wdata_sel = WD_REPL;
            w.blk_adv   = 1'b1;
            w.br_cond   = BR_BLK_MORE;
            w.br_target = STEP_RD0;
         end
         STEP_RESP: begin
            w.out_sel   = OUT_STATUS;
            w.br_cond   = BR_ALWAYS;
            w.br_target = STEP_IDLE;
         end
         default: begin
            w.br_cond   = BR_ALWAYS;
            w.br_target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

   // particle and wall rules; a block matching none stays as it is
   function automatic blk_type rule_apply(input blk_type b);
      blk_type r;
      r = b;
      case (b)
         {CELL_P, CELL_E, CELL_E, CELL_E}: r = {CELL_E, CELL_E, CELL_E, CELL_P};
         {CELL_E, CELL_E, CELL_E, CELL_P}: r = {CELL_P, CELL_E, CELL_E, CELL_E};
         {CELL_E, CELL_E, CELL_P, CELL_E}: r = {CELL_E, CELL_P, CELL_E, CELL_E};
         {CELL_E, CELL_P, CELL_E, CELL_E}: r = {CELL_E, CELL_E, CELL_P, CELL_E};
         {CELL_P, CELL_P, CELL_E, CELL_E}: r = {CELL_E, CELL_E, CELL_P, CELL_P};
         {CELL_E, CELL_E, CELL_P, CELL_P}: r = {CELL_P, CELL_P, CELL_E, CELL_E};
         {CELL_E, CELL_P, CELL_E, CELL_P}: r = {CELL_P, CELL_E, CELL_P, CELL_E};
         {CELL_P, CELL_E, CELL_P, CELL_E}: r = {CELL_E, CELL_P, CELL_E, CELL_P};
         {CELL_E, CELL_P, CELL_P, CELL_E}: r = {CELL_P, CELL_E, CELL_E, CELL_P};
         {CELL_P, CELL_E, CELL_E, CELL_P}: r = {CELL_E, CELL_P, CELL_P, CELL_E};
         {CELL_P, CELL_P, CELL_P, CELL_E}: r = {CELL_E, CELL_P, CELL_P, CELL_P};
         {CELL_E, CELL_P, CELL_P, CELL_P}: r = {CELL_P, CELL_P, CELL_P, CELL_E};
         {CELL_P, CELL_E, CELL_P, CELL_P}: r = {CELL_P, CELL_P, CELL_E, CELL_P};
         {CELL_P, CELL_P, CELL_E, CELL_P}: r = {CELL_P, CELL_E, CELL_P, CELL_P};
         {CELL_E, CELL_P, CELL_WALL, CELL_WALL}: r = {CELL_P, CELL_E, CELL_WALL, CELL_WALL};
         {CELL_P, CELL_E, CELL_WALL, CELL_WALL}: r = {CELL_E, CELL_P, CELL_WALL, CELL_WALL};
         {CELL_WALL, CELL_P, CELL_WALL, CELL_E}: r = {CELL_WALL, CELL_E, CELL_WALL, CELL_P};
         {CELL_WALL, CELL_E, CELL_WALL, CELL_P}: r = {CELL_WALL, CELL_P, CELL_WALL, CELL_E};
         {CELL_WALL, CELL_WALL, CELL_P, CELL_E}: r = {CELL_WALL, CELL_WALL, CELL_E, CELL_P};
         {CELL_WALL, CELL_WALL, CELL_E, CELL_P}: r = {CELL_WALL, CELL_WALL, CELL_P, CELL_E};
         {CELL_P, CELL_WALL, CELL_E, CELL_WALL}: r = {CELL_E, CELL_WALL, CELL_P, CELL_WALL};
         {CELL_E, CELL_WALL, CELL_P, CELL_WALL}: r = {CELL_P, CELL_WALL, CELL_E, CELL_WALL};
         default: r = b;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

[sv/mbas_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none
module mbas_ram #(
   parameter int unsigned WIDTH = 2,
   parameter int unsigned DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[sv/margolus_block_automaton_step_core.sv]
// top level: microcoded margolus block automaton step core with its grid store
// a generation walks the 2x2 blocks of the grid in row-major order
// the grid ram takes one access per step: each block needs 4 reads and 4 writes plus one match step
// one transaction at a time; the next is taken the cycle after the result is loaded
// reset (synchronous, active high) sets both dimensions to 64, then a clearing pass empties all 4096 cells
`default_nettype none
module margolus_block_automaton_step_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_valid,
   output      logic                                 req_stall,
   input  wire logic [mbas_pkg::OP_W-1:0]            req_op,
   input  wire logic [mbas_pkg::ROW_W-1:0]           req_row,
   input  wire logic [mbas_pkg::COL_W-1:0]           req_column,
   input  wire logic [mbas_pkg::CELL_W-1:0]          req_cell_value,
   input  wire logic                                 req_phase,
   // response channel
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_stall,
   output      logic [mbas_pkg::CELL_W-1:0]          rsp_read_value,
   output      logic [mbas_pkg::STATUS_W-1:0]        rsp_status,
   // configuration write channel
   input  wire logic                                 csr_valid,
   output      logic                                 csr_ready,
   input  wire logic [mbas_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [mbas_pkg::DIM_W-1:0]           csr_data
);

   // sequencer and control word of the current step
   mbas_pkg::step_type  upc_ff, upc_in;
   mbas_pkg::ucode_type uw;

   // clearing pass address
   logic [mbas_pkg::ADDR_W-1:0] clr_ff, clr_in;

   // configuration
   logic [mbas_pkg::DIM_W-1:0] grid_columns_ff, grid_columns_in;
   logic [mbas_pkg::DIM_W-1:0] grid_rows_ff, grid_rows_in;

   // captured transaction
   logic [mbas_pkg::ROW_W-1:0]    req_row_ff, req_row_in;
   logic [mbas_pkg::COL_W-1:0]    req_col_ff, req_col_in;
   logic [mbas_pkg::CELL_W-1:0]   req_value_ff, req_value_in;
   logic                          phase_ff, phase_in;
   logic [mbas_pkg::STATUS_W-1:0] status_ff, status_in;

   // block walk position and block contents
   logic [mbas_pkg::ROW_W-1:0]  blk_row_ff, blk_row_in;
   logic [mbas_pkg::COL_W-1:0]  blk_col_ff, blk_col_in;
   logic [mbas_pkg::CELL_W-1:0] blk_cell_ff [3];
   logic [mbas_pkg::CELL_W-1:0] blk_cell_in [3];
   mbas_pkg::blk_type           repl_ff, repl_in;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [mbas_pkg::CELL_W-1:0]   rsp_read_ff, rsp_read_in;
   logic [mbas_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   // ram ports
   logic                          mem_wr_en;
   logic                          mem_rd_en;
   logic [mbas_pkg::ADDR_W-1:0]   mem_addr;
   logic [mbas_pkg::CELL_W-1:0]   mem_wdata;
   logic [mbas_pkg::CELL_W-1:0]   mem_rdata;

   // decode of an incoming transaction
   logic [mbas_pkg::DIM_W-1:0]    eff_cols;
   logic [mbas_pkg::DIM_W-1:0]    eff_rows;
   logic                          req_accept;
   logic                          in_range;
   logic                          dims_odd;
   logic [mbas_pkg::DIM_W-1:0]    blk_min;
   logic                          dims_big;
   mbas_pkg::step_type            dispatch_step;
   logic [mbas_pkg::STATUS_W-1:0] dispatch_status;

   // walk and handshake helpers
   logic                          col_last;
   logic                          row_last;
   logic                          blk_more;
   logic                          clr_more;
   logic                          out_free;
   logic                          hold;

   // control word straight from the control store
   assign uw = mbas_pkg::ucode_word(upc_ff);

   // dimensions above the store size act as the store size
   assign eff_cols = (grid_columns_ff > mbas_pkg::DIM_W'(mbas_pkg::MAX_COLUMNS))
                     ? mbas_pkg::DIM_W'(mbas_pkg::MAX_COLUMNS) : grid_columns_ff;
   assign eff_rows = (grid_rows_ff > mbas_pkg::DIM_W'(mbas_pkg::MAX_ROWS))
                     ? mbas_pkg::DIM_W'(mbas_pkg::MAX_ROWS) : grid_rows_ff;

   // handshakes
   assign req_stall  = ~uw.take_req;
   assign req_accept = req_valid & uw.take_req;
   assign csr_ready  = 1'b1;
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;
   // a result step waits until the output register can take its result
   assign hold       = (uw.out_sel != mbas_pkg::OUT_NONE) & ~out_free;

   // op dispatch: pick the first program step and the status to report
   assign in_range = (mbas_pkg::DIM_W'(req_row) < eff_rows)
                   & (mbas_pkg::DIM_W'(req_column) < eff_cols);
   assign dims_odd = eff_rows[0] | eff_cols[0];
   // phase 1 needs room for one block inside the untouched border ring
   assign blk_min  = req_phase ? mbas_pkg::DIM_W'(4) : mbas_pkg::DIM_W'(2);
   assign dims_big = (eff_rows >= blk_min) & (eff_cols >= blk_min);

   always_comb begin
      dispatch_step   = mbas_pkg::STEP_RESP;
      dispatch_status = mbas_pkg::STATUS_OK;
      case (req_op)
         mbas_pkg::OP_WRITE: begin
            if (in_range) begin
               dispatch_step = mbas_pkg::STEP_WRITE;
            end else begin
               dispatch_status = mbas_pkg::STATUS_RANGE;
            end
         end
         mbas_pkg::OP_READ: begin
            if (in_range) begin
               dispatch_step = mbas_pkg::STEP_READ;
            end else begin
               dispatch_status = mbas_pkg::STATUS_RANGE;
            end
         end
         mbas_pkg::OP_GEN: begin
            // an odd grid is refused, an empty or tiny grid has no blocks
            if (dims_odd) begin
               dispatch_status = mbas_pkg::STATUS_ODD;
            end else if (dims_big) begin
               dispatch_step = mbas_pkg::STEP_RD0;
            end
         end
         default: begin
            dispatch_step   = mbas_pkg::STEP_RESP;
            dispatch_status = mbas_pkg::STATUS_OK;
         end
      endcase
   end

   // the last block of a row or of the grid ends one cell earlier in phase 1
   assign col_last = (mbas_pkg::SUM_W'(blk_col_ff) + mbas_pkg::SUM_W'(2)
                      + mbas_pkg::SUM_W'(phase_ff)) >= mbas_pkg::SUM_W'(eff_cols);
   assign row_last = (mbas_pkg::SUM_W'(blk_row_ff) + mbas_pkg::SUM_W'(2)
                      + mbas_pkg::SUM_W'(phase_ff)) >= mbas_pkg::SUM_W'(eff_rows);
   assign blk_more = ~(col_last & row_last);
   assign clr_more = (clr_ff != {mbas_pkg::ADDR_W{1'b1}});

   // sequencer: next step
   always_comb begin
      upc_in = upc_ff + mbas_pkg::step_type'(1);
      case (uw.br_cond)
         mbas_pkg::BR_NEXT:     upc_in = upc_ff + mbas_pkg::step_type'(1);
         mbas_pkg::BR_ALWAYS:   upc_in = uw.br_target;
         mbas_pkg::BR_DISPATCH: upc_in = req_valid ? dispatch_step : uw.br_target;
         mbas_pkg::BR_CLR_MORE: upc_in = clr_more ? uw.br_target
                                                  : upc_ff + mbas_pkg::step_type'(1);
         mbas_pkg::BR_BLK_MORE: upc_in = blk_more ? uw.br_target
                                                  : upc_ff + mbas_pkg::step_type'(1);
         default:               upc_in = mbas_pkg::STEP_IDLE;
      endcase
      if (hold) begin
         upc_in = upc_ff;
      end
   end

   // grid ram access
   always_comb begin
      mem_wr_en = (uw.mem_op == mbas_pkg::MEM_WRITE);
      mem_rd_en = (uw.mem_op == mbas_pkg::MEM_READ);
      case (uw.addr_sel)
         mbas_pkg::ADDR_CLEAR: mem_addr = clr_ff;
         mbas_pkg::ADDR_REQ:   mem_addr = {req_row_ff, req_col_ff};
         mbas_pkg::ADDR_BLK:   mem_addr = {blk_row_ff + mbas_pkg::ROW_W'(uw.cell_sel[1]),
                                           blk_col_ff + mbas_pkg::COL_W'(uw.cell_sel[0])};
         default:              mem_addr = clr_ff;
      endcase
      case (uw.wdata_sel)
         mbas_pkg::WD_ZERO: mem_wdata = mbas_pkg::CELL_E;
         mbas_pkg::WD_REQ:  mem_wdata = req_value_ff;
         mbas_pkg::WD_REPL: mem_wdata = repl_ff[uw.cell_sel];
         default:           mem_wdata = mbas_pkg::CELL_E;
      endcase
   end

   // datapath registers
   always_comb begin
      clr_in          = clr_ff;
      grid_columns_in = grid_columns_ff;
      grid_rows_in    = grid_rows_ff;
      req_row_in      = req_row_ff;
      req_col_in      = req_col_ff;
      req_value_in    = req_value_ff;
      phase_in        = phase_ff;
      status_in       = status_ff;
      blk_row_in      = blk_row_ff;
      blk_col_in      = blk_col_ff;
      blk_cell_in     = blk_cell_ff;
      repl_in         = repl_ff;
      rsp_valid_in    = rsp_valid_ff & rsp_stall;
      rsp_read_in     = rsp_read_ff;
      rsp_status_in   = rsp_status_ff;

      // configuration writes are taken at any time
      if (csr_valid) begin
         case (csr_index)
            mbas_pkg::CSR_GRID_COLUMNS: grid_columns_in = csr_data;
            mbas_pkg::CSR_GRID_ROWS:    grid_rows_in    = csr_data;
            default: begin
               grid_columns_in = grid_columns_ff;
               grid_rows_in    = grid_rows_ff;
            end
         endcase
      end

      if (uw.clr_inc) begin
         clr_in = clr_ff + mbas_pkg::ADDR_W'(1);
      end

      // capture the transaction and place the first block
      if (req_accept) begin
         req_row_in   = req_row;
         req_col_in   = req_column;
         req_value_in = req_cell_value;
         phase_in     = req_phase;
         status_in    = dispatch_status;
         blk_row_in   = mbas_pkg::ROW_W'(req_phase);
         blk_col_in   = mbas_pkg::COL_W'(req_phase);
      end

      // cell data comes back in the step after its read
      if (uw.latch_en) begin
         blk_cell_in[uw.latch_idx] = mem_rdata;
      end
      if (uw.latch_repl) begin
         repl_in = mbas_pkg::rule_apply({blk_cell_ff[0], blk_cell_ff[1],
                                         blk_cell_ff[2], mem_rdata});
      end

      // row-major walk over the blocks
      if (uw.blk_adv) begin
         if (col_last) begin
            blk_col_in = mbas_pkg::COL_W'(phase_ff);
            blk_row_in = blk_row_ff + mbas_pkg::ROW_W'(2);
         end else begin
            blk_col_in = blk_col_ff + mbas_pkg::COL_W'(2);
         end
      end

      // load the result
      if ((uw.out_sel != mbas_pkg::OUT_NONE) && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_read_in   = (uw.out_sel == mbas_pkg::OUT_READ) ? mem_rdata : mbas_pkg::CELL_E;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff          <= mbas_pkg::STEP_CLEAR;
         clr_ff          <= '0;
         grid_columns_ff <= mbas_pkg::GRID_COLUMNS_RST;
         grid_rows_ff    <= mbas_pkg::GRID_ROWS_RST;
         rsp_valid_ff    <= 1'b0;
      end else begin
         upc_ff          <= upc_in;
         clr_ff          <= clr_in;
         grid_columns_ff <= grid_columns_in;
         grid_rows_ff    <= grid_rows_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_row_ff    <= req_row_in;
      req_col_ff    <= req_col_in;
      req_value_ff  <= req_value_in;
      phase_ff      <= phase_in;
      status_ff     <= status_in;
      blk_row_ff    <= blk_row_in;
      blk_col_ff    <= blk_col_in;
      blk_cell_ff   <= blk_cell_in;
      repl_ff       <= repl_in;
      rsp_read_ff   <= rsp_read_in;
      rsp_status_ff <= rsp_status_in;
   end

   // grid store
   mbas_ram #(
      .WIDTH (mbas_pkg::CELL_W),
      .DEPTH (mbas_pkg::GRID_DEPTH)
   ) u_grid_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_addr),
      .wr_data (mem_wdata),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_addr),
      .rd_data (mem_rdata)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_ff;
   assign rsp_status     = rsp_status_ff;

endmodule
`default_nettype wire

[tb/sv/tb.sv]
// self-checking testbench for the margolus block automaton step core
module tb;

   // cell codes and the op code the block leaves unused
   localparam int CELL_BITS = 2;
   localparam logic [CELL_BITS-1:0] EMP = 2'd0;
   localparam logic [CELL_BITS-1:0] PRT = 2'd1;
   localparam logic [CELL_BITS-1:0] WAL = 2'd2;
   localparam logic [CELL_BITS-1:0] OTH = 2'd3;
   localparam logic [mbas_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   // run length and watchdog
   localparam int ITEM_TARGET     = 555;
   localparam int QUIET_LIMIT     = 50000;
   localparam int MISMATCH_PRINTS = 10;

   // block rules: bits 15:8 hold the match (tl, tr, bl, br), bits 7:0 the replacement
   localparam logic [0:21][15:0] BLOCK_RULES = {
      {PRT, EMP, EMP, EMP, EMP, EMP, EMP, PRT},
      {EMP, EMP, EMP, PRT, PRT, EMP, EMP, EMP},
      {EMP, EMP, PRT, EMP, EMP, PRT, EMP, EMP},
      {EMP, PRT, EMP, EMP, EMP, EMP, PRT, EMP},
      {PRT, PRT, EMP, EMP, EMP, EMP, PRT, PRT},
      {EMP, EMP, PRT, PRT, PRT, PRT, EMP, EMP},
      {EMP, PRT, EMP, PRT, PRT, EMP, PRT, EMP},
      {PRT, EMP, PRT, EMP, EMP, PRT, EMP, PRT},
      {EMP, PRT, PRT, EMP, PRT, EMP, EMP, PRT},
      {PRT, EMP, EMP, PRT, EMP, PRT, PRT, EMP},
      {PRT, PRT, PRT, EMP, EMP, PRT, PRT, PRT},
      {EMP, PRT, PRT, PRT, PRT, PRT, PRT, EMP},
      {PRT, EMP, PRT, PRT, PRT, PRT, EMP, PRT},
      {PRT, PRT, EMP, PRT, PRT, EMP, PRT, PRT},
      {EMP, PRT, WAL, WAL, PRT, EMP, WAL, WAL},
      {PRT, EMP, WAL, WAL, EMP, PRT, WAL, WAL},
      {WAL, PRT, WAL, EMP, WAL, EMP, WAL, PRT},
      {WAL, EMP, WAL, PRT, WAL, PRT, WAL, EMP},
      {WAL, WAL, PRT, EMP, WAL, WAL, EMP, PRT},
      {WAL, WAL, EMP, PRT, WAL, WAL, PRT, EMP},
      {PRT, WAL, EMP, WAL, EMP, WAL, PRT, WAL},
      {EMP, WAL, PRT, WAL, PRT, WAL, EMP, WAL}
   };

   typedef struct packed {
      logic [mbas_pkg::OP_W-1:0]  op;
      logic [mbas_pkg::ROW_W-1:0] row;
      logic [mbas_pkg::COL_W-1:0] column;
      logic [CELL_BITS-1:0]       cell_value;
      logic                       phase;
   } cell_cmd_type;

   typedef struct packed {
      logic [CELL_BITS-1:0]          read_value;
      logic [mbas_pkg::STATUS_W-1:0] status;
   } cell_rsp_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // request channel, driven from the tb
   logic                       req_valid      = 1'b0;
   logic                       req_stall;
   logic [mbas_pkg::OP_W-1:0]  req_op         = '0;
   logic [mbas_pkg::ROW_W-1:0] req_row        = '0;
   logic [mbas_pkg::COL_W-1:0] req_column     = '0;
   logic [CELL_BITS-1:0]       req_cell_value = '0;
   logic                       req_phase      = 1'b0;

   // response channel
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [CELL_BITS-1:0]          rsp_read_value;
   logic [mbas_pkg::STATUS_W-1:0] rsp_status;

   // register write channel
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [mbas_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [mbas_pkg::DIM_W-1:0]     csr_data  = '0;

   // shadow of the grid store and the geometry registers
   logic [CELL_BITS-1:0]       grid_model [mbas_pkg::MAX_ROWS][mbas_pkg::MAX_COLUMNS];
   logic [mbas_pkg::DIM_W-1:0] model_columns = mbas_pkg::GRID_COLUMNS_RST;
   logic [mbas_pkg::DIM_W-1:0] model_rows    = mbas_pkg::GRID_ROWS_RST;

   // commands waiting to go out and responses still owed by the block
   cell_cmd_type cmd_backlog [$];
   cell_rsp_type owed_rsps [$];
   cell_cmd_type sent_cmd;
   cell_cmd_type next_cmd;
   cell_rsp_type due_rsp;

   // idle percentages for the two sides, changed between episodes
   int send_gap_pct = 18;
   int recv_gap_pct = 47;

   int mismatches   = 0;
   int quiet_cycles = 0;
   int queued       = 0;

   margolus_block_automaton_step_core uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_row        (req_row),
      .req_column     (req_column),
      .req_cell_value (req_cell_value),
      .req_phase      (req_phase),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // register values above the store size behave as the store size
   function automatic int clamp_dim(input int d, input int limit);
      return (d > limit) ? limit : d;
   endfunction

   // mostly particles and empties so that the rule table gets hit
   function automatic int pick_cell();
      int r;
      r = $urandom_range(99);
      if (r < 40) return EMP;
      if (r < 75) return PRT;
      if (r < 95) return WAL;
      return OTH;
   endfunction

   // apply one command to the shadow grid and return the response it owes
   function automatic cell_rsp_type automaton_step(input cell_cmd_type c);
      cell_rsp_type res;
      int rows, cols, row_i, col_i, r0, c0, k;
      logic hit;
      logic [7:0] blk, repl;
      res = '0;
      rows  = clamp_dim(model_rows, mbas_pkg::MAX_ROWS);
      cols  = clamp_dim(model_columns, mbas_pkg::MAX_COLUMNS);
      row_i = c.row;
      col_i = c.column;
      case (c.op)
         mbas_pkg::OP_WRITE, mbas_pkg::OP_READ: begin
            if (row_i >= rows || col_i >= cols) begin
               res.status = mbas_pkg::STATUS_RANGE;
            end else if (c.op == mbas_pkg::OP_WRITE) begin
               grid_model[row_i][col_i] = c.cell_value;
            end else begin
               res.read_value = grid_model[row_i][col_i];
            end
         end
         mbas_pkg::OP_GEN: begin
            if ((rows % 2) != 0 || (cols % 2) != 0) begin
               res.status = mbas_pkg::STATUS_ODD;
            end else begin
               // odd offset stops one short so the border ring is left alone
               for (r0 = c.phase; r0 + 1 + c.phase < rows; r0 += 2) begin
                  for (c0 = c.phase; c0 + 1 + c.phase < cols; c0 += 2) begin
                     blk = {grid_model[r0][c0], grid_model[r0][c0+1],
                            grid_model[r0+1][c0], grid_model[r0+1][c0+1]};
                     hit = 1'b0;
                     repl = blk;
                     for (k = 0; k < 22; k++) begin
                        if (!hit && BLOCK_RULES[k][15:8] == blk) begin
                           hit = 1'b1;
                           repl = BLOCK_RULES[k][7:0];
                        end
                     end
                     grid_model[r0][c0]     = repl[7:6];
                     grid_model[r0][c0+1]   = repl[5:4];
                     grid_model[r0+1][c0]   = repl[3:2];
                     grid_model[r0+1][c0+1] = repl[1:0];
                  end
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic flag_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MISMATCH_PRINTS)
         $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   task automatic enqueue_cmd(input int op, input int row, input int column,
                              input int value, input int phase);
      cell_cmd_type c;
      c.op         = op[mbas_pkg::OP_W-1:0];
      c.row        = row[mbas_pkg::ROW_W-1:0];
      c.column     = column[mbas_pkg::COL_W-1:0];
      c.cell_value = value[CELL_BITS-1:0];
      c.phase      = phase[0];
      cmd_backlog.push_back(c);
      queued++;
   endtask

   // wait until every command has gone out and every response came back
   task automatic drain();
      while (cmd_backlog.size() != 0 || req_valid || owed_rsps.size() != 0)
         @(posedge clock);
   endtask

   // writes both geometry registers back to back; valid stays high across them
   task automatic set_geometry(input logic [mbas_pkg::DIM_W-1:0] cols,
                               input logic [mbas_pkg::DIM_W-1:0] rows);
      csr_valid <= 1'b1;
      csr_index <= mbas_pkg::CSR_GRID_COLUMNS;
      csr_data  <= cols;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      model_columns = cols;
      csr_index <= mbas_pkg::CSR_GRID_ROWS;
      csr_data  <= rows;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      model_rows = rows;
      csr_valid <= 1'b0;
   endtask

   // request driver: predicts at acceptance, then offers the next queued command
   always @(posedge clock) begin
      if (req_valid && !req_stall) begin
         sent_cmd = {req_op, req_row, req_column, req_cell_value, req_phase};
         owed_rsps.push_back(automaton_step(sent_cmd));
      end
      // a held item stays put while stalled; a free slot may idle at random
      if (!reset && (!req_valid || !req_stall)) begin
         if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            next_cmd = cmd_backlog.pop_front();
            req_valid      <= 1'b1;
            req_op         <= next_cmd.op;
            req_row        <= next_cmd.row;
            req_column     <= next_cmd.column;
            req_cell_value <= next_cmd.cell_value;
            req_phase      <= next_cmd.phase;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response monitor: each accepted response against the oldest owed one
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         if (owed_rsps.size() == 0) begin
            flag_mismatch($sformatf("response with none outstanding: read_value %0d status %0d",
                                    rsp_read_value, rsp_status));
         end else begin
            due_rsp = owed_rsps.pop_front();
            if (rsp_read_value !== due_rsp.read_value)
               flag_mismatch($sformatf("read_value expected %0d, got %0d",
                                       due_rsp.read_value, rsp_read_value));
            if (rsp_status !== due_rsp.status)
               flag_mismatch($sformatf("status expected %0d, got %0d",
                                       due_rsp.status, rsp_status));
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_gap_pct);
   end

   // watchdog: any transaction on any channel restarts the count
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // stimulus
   initial begin
      int i, j, ep_end, kind, k, p, er, ec, r0, c0, gens_left, pick;
      logic [mbas_pkg::DIM_W-1:0] cols_cfg, rows_cfg;
      logic [15:0] rule_word;

      for (i = 0; i < mbas_pkg::MAX_ROWS; i++)
         for (j = 0; j < mbas_pkg::MAX_COLUMNS; j++)
            grid_model[i][j] = EMP;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset geometry 64 x 64; the store must read back empty after the clearing pass
      enqueue_cmd(mbas_pkg::OP_READ, 0, 0, OTH, 1);
      enqueue_cmd(mbas_pkg::OP_READ, 63, 63, EMP, 0);
      enqueue_cmd(mbas_pkg::OP_WRITE, 0, 0, PRT, 0);
      enqueue_cmd(mbas_pkg::OP_WRITE, 63, 63, WAL, 1);
      enqueue_cmd(mbas_pkg::OP_WRITE, 62, 62, OTH, 0);
      // lone particle crosses the origin block, then the odd-offset block
      enqueue_cmd(mbas_pkg::OP_GEN, 0, 0, EMP, 0);
      enqueue_cmd(mbas_pkg::OP_READ, 1, 1, EMP, 0);
      enqueue_cmd(mbas_pkg::OP_GEN, 63, 63, OTH, 1);
      enqueue_cmd(mbas_pkg::OP_READ, 2, 2, EMP, 1);
      // a block holding an 'other' cell never matches
      enqueue_cmd(mbas_pkg::OP_READ, 62, 62, EMP, 0);
      enqueue_cmd(OP_UNUSED, 63, 63, OTH, 1);
      drain();

      // columns above the store size act as the store size
      set_geometry(7'd100, 7'd6);
      enqueue_cmd(mbas_pkg::OP_WRITE, 5, 63, PRT, 0);
      enqueue_cmd(mbas_pkg::OP_READ, 6, 0, EMP, 0);
      enqueue_cmd(mbas_pkg::OP_GEN, 0, 0, EMP, 1);
      // bottom-right border cell survives an odd-offset generation
      enqueue_cmd(mbas_pkg::OP_READ, 5, 63, EMP, 0);
      drain();

      // odd row count: generation refused, plain accesses still fine
      set_geometry(7'd64, 7'd5);
      enqueue_cmd(mbas_pkg::OP_GEN, 0, 0, EMP, 0);
      enqueue_cmd(mbas_pkg::OP_WRITE, 4, 63, WAL, 0);
      enqueue_cmd(mbas_pkg::OP_READ, 4, 63, EMP, 1);
      drain();

      // zero geometry: empty generation, every access out of range
      set_geometry(7'd0, 7'd0);
      enqueue_cmd(mbas_pkg::OP_GEN, 0, 0, EMP, 0);
      enqueue_cmd(mbas_pkg::OP_READ, 0, 0, EMP, 0);
      enqueue_cmd(mbas_pkg::OP_WRITE, 0, 0, PRT, 1);
      drain();

      // 127 would be odd if it were not clamped first
      set_geometry(7'd127, 7'd127);
      enqueue_cmd(mbas_pkg::OP_GEN, 0, 0, EMP, 0);
      enqueue_cmd(mbas_pkg::OP_READ, 5, 63, EMP, 0);

      // random episodes: pick a geometry, then mostly planted rule blocks with generations
      while (queued < ITEM_TARGET) begin
         drain();
         if (queued < ITEM_TARGET / 3) begin
            send_gap_pct = 18;
            recv_gap_pct = 47;
         end else if (queued < 2 * ITEM_TARGET / 3) begin
            send_gap_pct = 47;
            recv_gap_pct = 18;
         end else begin
            send_gap_pct = 0;
            recv_gap_pct = 0;
         end

         pick = $urandom_range(99);
         gens_left = 1000;
         if (pick < 66) begin
            cols_cfg = mbas_pkg::DIM_W'(2 * $urandom_range(1, 8));
            rows_cfg = mbas_pkg::DIM_W'(2 * $urandom_range(1, 8));
         end else if (pick < 74) begin
            // wide strip, full column range at little cost
            cols_cfg = mbas_pkg::DIM_W'(2 * $urandom_range(1, 32));
            rows_cfg = mbas_pkg::DIM_W'(2 * $urandom_range(1, 2));
         end else if (pick < 92) begin
            // odd and zero dimensions turn up here
            cols_cfg = mbas_pkg::DIM_W'($urandom_range(0, 17));
            rows_cfg = mbas_pkg::DIM_W'($urandom_range(0, 17));
         end else begin
            // full store, a single generation since it runs long
            cols_cfg = mbas_pkg::DIM_W'($urandom_range(64, 127));
            rows_cfg = mbas_pkg::DIM_W'($urandom_range(64, 127));
            gens_left = 1;
         end
         set_geometry(cols_cfg, rows_cfg);
         er = clamp_dim(rows_cfg, mbas_pkg::MAX_ROWS);
         ec = clamp_dim(cols_cfg, mbas_pkg::MAX_COLUMNS);

         ep_end = queued + $urandom_range(20, 45);
         while (queued < ep_end) begin
            kind = $urandom_range(99);
            p = $urandom_range(1);
            if (kind < 35 && (er - 2 * p) / 2 >= 1 && (ec - 2 * p) / 2 >= 1) begin
               // plant a rule pattern on a block of this offset, usually step, read it back
               k = $urandom_range(21);
               rule_word = BLOCK_RULES[k];
               r0 = p + 2 * $urandom_range((er - 2 * p) / 2 - 1);
               c0 = p + 2 * $urandom_range((ec - 2 * p) / 2 - 1);
               enqueue_cmd(mbas_pkg::OP_WRITE, r0, c0, rule_word[15:14], $urandom_range(1));
               enqueue_cmd(mbas_pkg::OP_WRITE, r0, c0 + 1, rule_word[13:12], $urandom_range(1));
               enqueue_cmd(mbas_pkg::OP_WRITE, r0 + 1, c0, rule_word[11:10], $urandom_range(1));
               enqueue_cmd(mbas_pkg::OP_WRITE, r0 + 1, c0 + 1, rule_word[9:8],
                           $urandom_range(1));
               if (gens_left > 0 && $urandom_range(9) < 7) begin
                  enqueue_cmd(mbas_pkg::OP_GEN, $urandom_range(63), $urandom_range(63),
                              $urandom_range(3), p);
                  gens_left--;
               end
               enqueue_cmd(mbas_pkg::OP_READ, r0, c0, $urandom_range(3), $urandom_range(1));
               enqueue_cmd(mbas_pkg::OP_READ, r0, c0 + 1, $urandom_range(3),
                           $urandom_range(1));
               enqueue_cmd(mbas_pkg::OP_READ, r0 + 1, c0, $urandom_range(3),
                           $urandom_range(1));
               enqueue_cmd(mbas_pkg::OP_READ, r0 + 1, c0 + 1, $urandom_range(3),
                           $urandom_range(1));
            end else if (kind < 55 && er > 0 && ec > 0) begin
               enqueue_cmd(mbas_pkg::OP_WRITE, $urandom_range(er - 1), $urandom_range(ec - 1),
                           pick_cell(), $urandom_range(1));
            end else if (kind < 70 && er > 0 && ec > 0) begin
               enqueue_cmd(mbas_pkg::OP_READ, $urandom_range(er - 1), $urandom_range(ec - 1),
                           $urandom_range(3), $urandom_range(1));
            end else if (kind < 80) begin
               // anywhere in the address space, mostly out of range on small grids
               enqueue_cmd($urandom_range(1) ? mbas_pkg::OP_READ : mbas_pkg::OP_WRITE,
                           $urandom_range(63), $urandom_range(63), $urandom_range(3),
                           $urandom_range(1));
            end else if (kind < 92 && gens_left > 0) begin
               enqueue_cmd(mbas_pkg::OP_GEN, $urandom_range(63), $urandom_range(63),
                           $urandom_range(3), p);
               gens_left--;
            end else begin
               enqueue_cmd(OP_UNUSED, $urandom_range(63), $urandom_range(63),
                           $urandom_range(3), p);
            end
         end
      end

      drain();
      // room for a stray response after the last owed one
      repeat (16) @(posedge clock);
      if (mismatches == 0 && owed_rsps.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
